/* design/usp_pkg.sv */
package usp_pkg;

	// width of every offset and length field on the result channel
	localparam int FIELD_W = 12;

	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	// prefixes that make an opaque URL acceptable
	localparam int MAILTO_LEN = 7;  // "mailto:"
	localparam int NEWS_LEN   = 5;  // "news:"
	localparam int MAILTO_SCHEME_LEN = 6;
	localparam int NEWS_SCHEME_LEN   = 4;

	typedef enum logic [8:0] {
		PH_SCHEME     = 9'b000000001,
		PH_SLASH1     = 9'b000000010,
		PH_SLASH2     = 9'b000000100,
		PH_AUTH       = 9'b000001000,
		PH_AUTH_COLON = 9'b000010000,
		PH_HOST2      = 9'b000100000,
		PH_REST       = 9'b001000000,
		PH_OPAQUE     = 9'b010000000,
		PH_FAIL       = 9'b100000000
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   mailto_match;
		logic   news_match;
		logic   overflow;
	} ctrl_t;

	typedef struct packed {
		logic               url_ok;
		logic [FIELD_W-1:0] scheme_len;
		logic [FIELD_W-1:0] user_len;
		logic [FIELD_W-1:0] pass_len;
		logic [FIELD_W-1:0] host_start;
		logic [FIELD_W-1:0] host_len;
		logic [FIELD_W-1:0] rest_start;
		logic [FIELD_W-1:0] rest_len;
		logic               too_long;
	} result_t;

	function automatic logic [7:0] mailto_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h6d;  // m
			3'd1: c = 8'h61;  // a
			3'd2: c = 8'h69;  // i
			3'd3: c = 8'h6c;  // l
			3'd4: c = 8'h74;  // t
			3'd5: c = 8'h6f;  // o
			3'd6: c = CH_COLON;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] news_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h6e;  // n
			3'd1: c = 8'h65;  // e
			3'd2: c = 8'h77;  // w
			3'd3: c = 8'h73;  // s
			3'd4: c = CH_COLON;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* design/usp_in_if.sv */
interface usp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

/* design/usp_out_if.sv */
interface usp_out_if;
	logic                        valid;
	logic                        ready;
	logic                        url_ok;
	logic [usp_pkg::FIELD_W-1:0] scheme_len;
	logic [usp_pkg::FIELD_W-1:0] user_len;
	logic [usp_pkg::FIELD_W-1:0] pass_len;
	logic [usp_pkg::FIELD_W-1:0] host_start;
	logic [usp_pkg::FIELD_W-1:0] host_len;
	logic [usp_pkg::FIELD_W-1:0] rest_start;
	logic [usp_pkg::FIELD_W-1:0] rest_len;
	logic                        too_long;

	modport source (output valid, output url_ok, output scheme_len, output user_len,
		output pass_len, output host_start, output host_len, output rest_start,
		output rest_len, output too_long, input ready);
	modport sink (input valid, input url_ok, input scheme_len, input user_len,
		input pass_len, input host_start, input host_len, input rest_start,
		input rest_len, input too_long, output ready);
endinterface

/* design/usp_scan.sv */
module usp_scan #(
	parameter int MAX_LEN = 4095,
	parameter int PW      = $clog2(MAX_LEN + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [7:0]     ch,
	input  logic           last,
	output usp_pkg::ctrl_t nxt_ctrl,
	output logic [PW-1:0]  nxt_pos,
	output logic [PW-1:0]  nxt_scheme,
	output logic [PW-1:0]  nxt_user,
	output logic [PW-1:0]  nxt_pass,
	output logic [PW-1:0]  nxt_host,
	output logic [PW-1:0]  nxt_rest
);

	usp_pkg::ctrl_t ctrl_q;
	logic [PW-1:0]  pos_q;
	logic [PW-1:0]  scheme_q;
	logic [PW-1:0]  user_q;
	logic [PW-1:0]  pass_q;
	logic [PW-1:0]  host_q;
	logic [PW-1:0]  rest_q;

	always_comb begin
		nxt_ctrl   = ctrl_q;
		nxt_pos    = pos_q;
		nxt_scheme = scheme_q;
		nxt_user   = user_q;
		nxt_pass   = pass_q;
		nxt_host   = host_q;
		nxt_rest   = rest_q;
		if (pos_q >= PW'(MAX_LEN)) begin
			// drop bytes past the length limit
			nxt_ctrl.overflow = 1'b1;
		end else begin
			nxt_pos = pos_q + PW'(1);
			unique case (ctrl_q.phase)
				usp_pkg::PH_SCHEME: begin
					if (pos_q < PW'(usp_pkg::MAILTO_LEN)) begin
						if (ch != usp_pkg::mailto_char(pos_q[2:0]))
							nxt_ctrl.mailto_match = 1'b0;
					end else begin
						nxt_ctrl.mailto_match = 1'b0;
					end
					if (pos_q < PW'(usp_pkg::NEWS_LEN)) begin
						if (ch != usp_pkg::news_char(pos_q[2:0]))
							nxt_ctrl.news_match = 1'b0;
					end else begin
						nxt_ctrl.news_match = 1'b0;
					end
					if (ch == usp_pkg::CH_COLON) begin
						if (pos_q == '0) begin
							nxt_ctrl.phase = usp_pkg::PH_FAIL;
						end else begin
							nxt_scheme     = pos_q;
							nxt_ctrl.phase = usp_pkg::PH_SLASH1;
						end
					end
				end
				usp_pkg::PH_SLASH1: begin
					if (ch == usp_pkg::CH_SLASH) begin
						nxt_ctrl.phase = usp_pkg::PH_SLASH2;
					end else begin
						nxt_rest       = pos_q;
						nxt_ctrl.phase = usp_pkg::PH_OPAQUE;
					end
				end
				usp_pkg::PH_SLASH2: begin
					if (ch == usp_pkg::CH_SLASH) begin
						nxt_host       = pos_q + PW'(1);
						nxt_ctrl.phase = usp_pkg::PH_AUTH;
					end else begin
						nxt_ctrl.phase = usp_pkg::PH_FAIL;
					end
				end
				usp_pkg::PH_AUTH, usp_pkg::PH_AUTH_COLON: begin
					priority if (ch == usp_pkg::CH_AT) begin
						if (ctrl_q.phase == usp_pkg::PH_AUTH) begin
							nxt_user = pos_q - host_q;
							nxt_pass = '0;
						end else begin
							nxt_pass = pos_q - host_q - user_q - PW'(1);
						end
						nxt_host       = pos_q + PW'(1);
						nxt_ctrl.phase = usp_pkg::PH_HOST2;
					end else if (ch == usp_pkg::CH_SLASH) begin
						nxt_user       = '0;
						nxt_pass       = '0;
						nxt_rest       = pos_q;
						nxt_ctrl.phase = usp_pkg::PH_REST;
					end else if (ch == usp_pkg::CH_COLON
							&& ctrl_q.phase == usp_pkg::PH_AUTH) begin
						nxt_user       = pos_q - host_q;
						nxt_ctrl.phase = usp_pkg::PH_AUTH_COLON;
					end else begin
						nxt_ctrl.phase = ctrl_q.phase;
					end
				end
				usp_pkg::PH_HOST2: begin
					if (ch == usp_pkg::CH_SLASH) begin
						nxt_rest       = pos_q;
						nxt_ctrl.phase = usp_pkg::PH_REST;
					end
				end
				usp_pkg::PH_REST, usp_pkg::PH_OPAQUE: begin
					nxt_ctrl.phase = ctrl_q.phase;
				end
				default: begin
					nxt_ctrl.phase = usp_pkg::PH_FAIL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= '{phase: usp_pkg::PH_SCHEME, mailto_match: 1'b1,
				news_match: 1'b1, overflow: 1'b0};
			pos_q    <= '0;
			scheme_q <= '0;
			user_q   <= '0;
			pass_q   <= '0;
			host_q   <= '0;
			rest_q   <= '0;
		end else if (en) begin
			if (last) begin
				// return to the initial state for the next URL
				ctrl_q   <= '{phase: usp_pkg::PH_SCHEME, mailto_match: 1'b1,
					news_match: 1'b1, overflow: 1'b0};
				pos_q    <= '0;
				scheme_q <= '0;
				user_q   <= '0;
				pass_q   <= '0;
				host_q   <= '0;
				rest_q   <= '0;
			end else begin
				ctrl_q   <= nxt_ctrl;
				pos_q    <= nxt_pos;
				scheme_q <= nxt_scheme;
				user_q   <= nxt_user;
				pass_q   <= nxt_pass;
				host_q   <= nxt_host;
				rest_q   <= nxt_rest;
			end
		end
	end

`ifndef SYNTH
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_LEN))
		else $error("position ran past the length limit");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		en && last |=> pos_q == '0 && ctrl_q.phase == usp_pkg::PH_SCHEME
			&& !ctrl_q.overflow)
		else $error("scanner did not restart after the final byte");
`endif

endmodule

/* design/usp_result.sv */
module usp_result #(
	parameter int PW = 12
) (
	input  usp_pkg::ctrl_t   ctrl,
	input  logic [PW-1:0]    len,
	input  logic [PW-1:0]    scheme,
	input  logic [PW-1:0]    user,
	input  logic [PW-1:0]    pass,
	input  logic [PW-1:0]    host,
	input  logic [PW-1:0]    rest,
	output usp_pkg::result_t res
);

	localparam int FW = usp_pkg::FIELD_W;

	logic          ok;
	logic [PW-1:0] ul, pl, hs, hl, rs, rl;

	always_comb begin
		ok = 1'b0;
		ul = '0;
		pl = '0;
		hs = '0;
		hl = '0;
		rs = '0;
		rl = '0;
		unique case (ctrl.phase)
			usp_pkg::PH_SLASH1, usp_pkg::PH_OPAQUE: begin
				ok = (scheme == PW'(usp_pkg::MAILTO_SCHEME_LEN) && ctrl.mailto_match)
					|| (scheme == PW'(usp_pkg::NEWS_SCHEME_LEN) && ctrl.news_match);
				// a URL ending right after the colon has an empty opaque part
				if (ctrl.phase == usp_pkg::PH_OPAQUE) begin
					rs = rest;
					rl = len - rest;
				end
			end
			usp_pkg::PH_AUTH, usp_pkg::PH_AUTH_COLON: begin
				ok = 1'b1;
				hs = host;
				hl = len - host;
			end
			usp_pkg::PH_REST: begin
				ok = 1'b1;
				ul = user;
				pl = pass;
				hs = host;
				hl = rest - host;
				rs = rest;
				rl = len - rest;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (ctrl.overflow)
			ok = 1'b0;
		if (hl == '0)
			hs = '0;
		if (rl == '0)
			rs = '0;

		res          = '0;
		res.too_long = ctrl.overflow;
		if (ok) begin
			res.url_ok     = 1'b1;
			res.scheme_len = FW'(scheme);
			res.user_len   = FW'(ul);
			res.pass_len   = FW'(pl);
			res.host_start = FW'(hs);
			res.host_len   = FW'(hl);
			res.rest_start = FW'(rs);
			res.rest_len   = FW'(rl);
		end
	end

endmodule

/* design/url_component_splitter_top.sv */
// URL component splitter.
// The chars channel carries one URL byte per transaction, with last set on
// the final byte. After the final byte the results channel gives one
// transaction: url_ok plus lengths of scheme, user, password, host:port and
// rest, and start offsets of host:port and rest. Rejected URLs report url_ok=0
// and zero fields; a URL longer than MAX_LEN bytes reports too_long=1 and
// url_ok=0. Throughput: one byte per cycle, sustained, including across URL
// boundaries, unless a final byte must wait for the result slot. Each byte
// goes through an input register and one pass of the scanner logic; a final
// byte loads its result into the result register, which raises results.valid.
// The output register holds a finished result while the receiver stalls;
// bytes of the next URL keep flowing through the scanner, and only a final
// byte waits in the input register until the result slot frees. Reset clears
// the scanner to the start of a URL and empties both registers; no clearing pass is needed.
module url_component_splitter_top #(
	parameter int MAX_LEN = 4095
) (
	input logic       clk,
	input logic       arst_n,
	usp_in_if.sink    chars,
	usp_out_if.source results
);

	localparam int PW = $clog2(MAX_LEN + 1);

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// result register
	logic             out_valid_q;
	usp_pkg::result_t out_res_q;

	logic             adv;
	usp_pkg::ctrl_t   nxt_ctrl;
	logic [PW-1:0]    nxt_pos, nxt_scheme, nxt_user, nxt_pass, nxt_host, nxt_rest;
	usp_pkg::result_t res;

	// advance the byte in stage 1 unless it is final and the result slot is busy
	assign adv = valid_s1 && (!last_s1 || !out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	usp_scan #(
		.MAX_LEN (MAX_LEN),
		.PW      (PW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.ch         (ch_s1),
		.last       (last_s1),
		.nxt_ctrl   (nxt_ctrl),
		.nxt_pos    (nxt_pos),
		.nxt_scheme (nxt_scheme),
		.nxt_user   (nxt_user),
		.nxt_pass   (nxt_pass),
		.nxt_host   (nxt_host),
		.nxt_rest   (nxt_rest)
	);

	usp_result #(
		.PW (PW)
	) u_result (
		.ctrl   (nxt_ctrl),
		.len    (nxt_pos),
		.scheme (nxt_scheme),
		.user   (nxt_user),
		.pass   (nxt_pass),
		.host   (nxt_host),
		.rest   (nxt_rest),
		.res    (res)
	);

	// load a result on the final byte; drop it once the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			out_res_q <= res;
	end

	assign results.valid      = out_valid_q;
	assign results.url_ok     = out_res_q.url_ok;
	assign results.scheme_len = out_res_q.scheme_len;
	assign results.user_len   = out_res_q.user_len;
	assign results.pass_len   = out_res_q.pass_len;
	assign results.host_start = out_res_q.host_start;
	assign results.host_len   = out_res_q.host_len;
	assign results.rest_start = out_res_q.rest_start;
	assign results.rest_len   = out_res_q.rest_len;
	assign results.too_long   = out_res_q.too_long;

`ifndef SYNTH
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> out_valid_q)
		else $error("final byte advanced without producing a result");

	a_final_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !results.ready |=> valid_s1 && last_s1)
		else $error("final byte lost while the result slot was busy");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_res_q.url_ok |-> out_res_q.scheme_len == '0
			&& out_res_q.host_len == '0 && out_res_q.rest_len == '0
			&& out_res_q.user_len == '0)
		else $error("rejected URL carries nonzero fields");

	a_too_long_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.too_long |-> !out_res_q.url_ok)
		else $error("overlong URL reported as accepted");
`endif

endmodule
